@@ src/mmde_pkg.sv @@
// Shared types, constants and helpers for the matrix multiply dot engine.
package mmde_pkg;

  localparam int MATRIX_DIM  = 32;
  localparam int STORE_DEPTH = MATRIX_DIM * MATRIX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int IDX_W       = (MATRIX_DIM > 1) ? $clog2(MATRIX_DIM) : 1;
  localparam int ELEM_W      = 32;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int ACC_W       = PROD_W + IDX_W;
  localparam int FRAC_W      = 16;
  localparam int SUM_W       = 48;
  localparam int ROW_W       = 5;
  localparam int FUNC_W      = 2;

  localparam logic [FUNC_W-1:0] FUNC_WR_A    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WR_B    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              we_a;
    logic              we_b;
    logic [ADDR_W-1:0] addr;
  } wr_req_t;

  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } step_t;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [31:0] r, input logic [31:0] c);
    int unsigned a;
    a = r * MATRIX_DIM + c;
    return a[ADDR_W-1:0];
  endfunction

endpackage

@@ src/matrix_multiply_dot_engine.sv @@
// Top level of the matrix multiply dot engine: sequencer, element stores, MAC, output register.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | func_i, row_i, col_i, element_value_i
//   out     | output    | out_valid_o / out_ready_i| product_sum_o, overflowed_o
//
// A compute item feeds one term per cycle through the single multiplier, then drains through
// the pipeline registers that hold the read data, the product and the running accumulation
// sum. in_ready_o is low for the whole compute. Reset clears control only; the element
// memories hold garbage until written. A result waiting on out_ready_i does not block
// further writes; a following compute holds until the output register frees.
module matrix_multiply_dot_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mmde_pkg::FUNC_W-1:0]         func_i,
  input  logic [mmde_pkg::ROW_W-1:0]          row_i,
  input  logic [mmde_pkg::ROW_W-1:0]          col_i,
  input  logic signed [mmde_pkg::ELEM_W-1:0]  element_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mmde_pkg::SUM_W-1:0]   product_sum_o,
  output logic                                overflowed_o
);

  mmde_pkg::wr_req_t              wr;
  mmde_pkg::step_t                step;
  logic                           rd_en, mac_done, load_out, zero, out_free, mac_ovf;
  logic [mmde_pkg::ADDR_W-1:0]    raddr_a, raddr_b;
  logic [mmde_pkg::ELEM_W-1:0]    a_data, b_data;
  logic [mmde_pkg::SUM_W-1:0]     mac_sum;
  logic                           out_valid_q, out_valid_d;
  logic [mmde_pkg::SUM_W-1:0]     sum_q, sum_d;
  logic                           ovf_q, ovf_d;

  assign out_free = ~out_valid_q | out_ready_i;

  mmde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .mac_done_i (mac_done),
    .out_free_i (out_free),
    .wr_o       (wr),
    .rd_en_o    (rd_en),
    .raddr_a_o  (raddr_a),
    .raddr_b_o  (raddr_b),
    .step_o     (step),
    .load_out_o (load_out),
    .zero_o     (zero)
  );

  mmde_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wdata_i   (element_value_i),
    .rd_en_i   (rd_en),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .a_o       (a_data),
    .b_o       (b_data)
  );

  mmde_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .a_i    (a_data),
    .b_i    (b_data),
    .done_o (mac_done),
    .sum_o  (mac_sum),
    .ovf_o  (mac_ovf)
  );

  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    sum_d       = sum_q;
    ovf_d       = ovf_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      sum_d       = zero ? '0 : mac_sum;
      ovf_d       = zero ? 1'b0 : mac_ovf;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    ovf_q <= ovf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign product_sum_o = sum_q;
  assign overflowed_o  = ovf_q;

endmodule

@@ src/mmde_store.sv @@
// Matrix A and matrix B element memories with registered read data.
module mmde_store (
  input  logic                            clk_i,
  input  mmde_pkg::wr_req_t               wr_i,
  input  logic [mmde_pkg::ELEM_W-1:0]     wdata_i,
  input  logic                            rd_en_i,
  input  logic [mmde_pkg::ADDR_W-1:0]     raddr_a_i,
  input  logic [mmde_pkg::ADDR_W-1:0]     raddr_b_i,
  output logic [mmde_pkg::ELEM_W-1:0]     a_o,
  output logic [mmde_pkg::ELEM_W-1:0]     b_o
);

  logic [mmde_pkg::ELEM_W-1:0] mem_a [mmde_pkg::STORE_DEPTH];
  logic [mmde_pkg::ELEM_W-1:0] mem_b [mmde_pkg::STORE_DEPTH];
  logic [mmde_pkg::ELEM_W-1:0] a_q;
  logic [mmde_pkg::ELEM_W-1:0] b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we_a) begin
      mem_a[wr_i.addr] <= wdata_i;
    end
    if (rd_en_i) begin
      a_q <= mem_a[raddr_a_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.we_b) begin
      mem_b[wr_i.addr] <= wdata_i;
    end
    if (rd_en_i) begin
      b_q <= mem_b[raddr_b_i];
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

@@ src/mmde_mac.sv @@
// Shared multiply-accumulate unit with floor shift and 48-bit saturation.
module mmde_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mmde_pkg::step_t                     step_i,
  input  logic signed [mmde_pkg::ELEM_W-1:0]  a_i,
  input  logic signed [mmde_pkg::ELEM_W-1:0]  b_i,
  output logic                                done_o,
  output logic [mmde_pkg::SUM_W-1:0]          sum_o,
  output logic                                ovf_o
);

  localparam int SH_W = mmde_pkg::ACC_W - mmde_pkg::FRAC_W;

  logic signed [mmde_pkg::PROD_W-1:0] prod_q;
  mmde_pkg::step_t                    step_q;
  logic [mmde_pkg::ACC_W-1:0]         acc_q, acc_d, prod_ext;
  logic                               done_q;
  logic [SH_W-1:0]                    sh;
  logic [SH_W-mmde_pkg::SUM_W:0]      top;
  logic                               fits;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_ext = {{(mmde_pkg::ACC_W - mmde_pkg::PROD_W){prod_q[mmde_pkg::PROD_W-1]}},
                     prod_q};

  always_comb begin
    acc_d = acc_q;
    if (step_q.vld) begin
      acc_d = step_q.first ? prod_ext : acc_q + prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_i;
      done_q <= step_q.vld & step_q.last;
    end
  end

  assign sh   = acc_q[mmde_pkg::ACC_W-1:mmde_pkg::FRAC_W];
  assign top  = sh[SH_W-1:mmde_pkg::SUM_W-1];
  assign fits = (&top) | ~(|top);

  always_comb begin
    if (fits) begin
      sum_o = sh[mmde_pkg::SUM_W-1:0];
      ovf_o = 1'b0;
    end else begin
      sum_o = acc_q[mmde_pkg::ACC_W-1] ? {1'b1, {(mmde_pkg::SUM_W-1){1'b0}}}
                                       : {1'b0, {(mmde_pkg::SUM_W-1){1'b1}}};
      ovf_o = 1'b1;
    end
  end

  assign done_o = done_q;

endmodule

@@ src/mmde_ctrl.sv @@
// Sequencer: decodes items, steps the dot product index and hands off results.
module mmde_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mmde_pkg::FUNC_W-1:0]     func_i,
  input  logic [mmde_pkg::ROW_W-1:0]      row_i,
  input  logic [mmde_pkg::ROW_W-1:0]      col_i,
  input  logic                            mac_done_i,
  input  logic                            out_free_i,
  output mmde_pkg::wr_req_t               wr_o,
  output logic                            rd_en_o,
  output logic [mmde_pkg::ADDR_W-1:0]     raddr_a_o,
  output logic [mmde_pkg::ADDR_W-1:0]     raddr_b_o,
  output mmde_pkg::step_t                 step_o,
  output logic                            load_out_o,
  output logic                            zero_o
);

  localparam logic [mmde_pkg::IDX_W-1:0] K_LAST = mmde_pkg::IDX_W'(mmde_pkg::MATRIX_DIM - 1);

  mmde_pkg::state_e               state_q, state_d;
  logic [mmde_pkg::IDX_W-1:0]     i_q, i_d, j_q, j_d, k_q, k_d;
  logic                           zero_q, zero_d;
  mmde_pkg::step_t                step_q, step_d;
  logic                           accept, in_range;

  assign in_range = (32'(row_i) < mmde_pkg::MATRIX_DIM) && (32'(col_i) < mmde_pkg::MATRIX_DIM);
  assign accept   = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mmde_pkg::ST_IDLE: begin
        if (accept && func_i == mmde_pkg::FUNC_COMPUTE) begin
          state_d = in_range ? mmde_pkg::ST_RUN : mmde_pkg::ST_DONE;
        end
      end
      mmde_pkg::ST_RUN: begin
        if (k_q == K_LAST) begin
          state_d = mmde_pkg::ST_DRAIN;
        end
      end
      mmde_pkg::ST_DRAIN: begin
        if (mac_done_i) begin
          state_d = mmde_pkg::ST_DONE;
        end
      end
      mmde_pkg::ST_DONE: begin
        if (out_free_i) begin
          state_d = mmde_pkg::ST_IDLE;
        end
      end
      default: state_d = mmde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == mmde_pkg::ST_IDLE);
    wr_o.addr  = mmde_pkg::addr_of(32'(row_i), 32'(col_i));
    wr_o.we_a  = accept && in_range && func_i == mmde_pkg::FUNC_WR_A;
    wr_o.we_b  = accept && in_range && func_i == mmde_pkg::FUNC_WR_B;
    rd_en_o    = (state_q == mmde_pkg::ST_RUN);
    raddr_a_o  = mmde_pkg::addr_of(32'(i_q), 32'(k_q));
    raddr_b_o  = mmde_pkg::addr_of(32'(k_q), 32'(j_q));
    load_out_o = (state_q == mmde_pkg::ST_DONE) && out_free_i;
    zero_o     = zero_q;
    step_o     = step_q;
  end

  always_comb begin
    i_d    = i_q;
    j_d    = j_q;
    k_d    = k_q;
    zero_d = zero_q;
    if (accept) begin
      i_d    = mmde_pkg::IDX_W'(row_i);
      j_d    = mmde_pkg::IDX_W'(col_i);
      k_d    = '0;
      zero_d = ~in_range;
    end else if (state_q == mmde_pkg::ST_RUN) begin
      k_d = k_q + 1'b1;
    end
    step_d.vld   = (state_q == mmde_pkg::ST_RUN);
    step_d.first = (k_q == '0);
    step_d.last  = (k_q == K_LAST);
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    k_q    <= k_d;
    zero_q <= zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmde_pkg::ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule
